### hw/rtl/pkl_pkg.sv
// ----------------------------------------------------------------------------
// pkl_pkg
// Shared types and constants for the per-key concurrency limiter.
// ----------------------------------------------------------------------------
`default_nettype none
package pkl_pkg;
   localparam int unsigned TABLE_ENTRIES_DEF = 256;
   localparam int unsigned KEY_BITS_DEF      = 64;
   localparam int unsigned KEY_MAX_BITS      = 64;
   localparam int unsigned CSR_IDX_W         = 1;
   localparam int unsigned CSR_DATA_W        = 16;
   localparam logic [15:0] MAX_CONNS_RST     = 16'd1;
   localparam logic [9:0]  REJECT_STATUS_RST = 10'd503;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_CONNS     = 1'b0,
      CSR_REJECT_STATUS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      V_NEW      = 3'd0,
      V_ALLOWED  = 3'd1,
      V_OVER     = 3'd2,
      V_FULL     = 3'd3,
      V_NOKEY    = 3'd4,
      V_RELEASED = 3'd5,
      V_FREED    = 3'd6,
      V_UNKNOWN  = 3'd7
   } verdict_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } eng_state_type;

   typedef struct packed {
      logic                    op;
      logic                    present;
      logic [KEY_MAX_BITS-1:0] key;
   } item_type;

   typedef struct packed {
      logic        vld;
      item_type    item;
   } head_type;

   typedef struct packed {
      logic [15:0] max_conns;
      logic [9:0]  reject_status;
   } cfg_type;

   typedef struct packed {
      logic        vld;
      verdict_type verdict;
      logic [15:0] count_after;
      logic [9:0]  http_status;
   } result_type;
endpackage
`default_nettype wire

### hw/rtl/pkl_front.sv
// ----------------------------------------------------------------------------
// pkl_front
// Accepts requests, masks the key and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module pkl_front import pkl_pkg::*; #(
   parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic                    req_op,
   input  wire logic                    req_key_present,
   input  wire logic [KEY_MAX_BITS-1:0] req_client_key,
   input  wire logic                    pop,
   output head_type                     head
);
   localparam logic [KEY_MAX_BITS-1:0] KEY_MASK = {KEY_MAX_BITS{1'b1}} >> (KEY_MAX_BITS - KEY_BITS);

   item_type    q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        accept;

   assign busy   = (cnt_ff == 2'd2);
   assign accept = start && !busy;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ accept;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, accept} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= '{op: req_op, present: req_key_present,
                              key: req_client_key & KEY_MASK};
      end
   end

   assign head.vld  = (cnt_ff != 2'd0);
   assign head.item = q_ff[rd_ptr_ff];
endmodule
`default_nettype wire

### hw/rtl/pkl_engine.sv
// ----------------------------------------------------------------------------
// pkl_engine
// Scans the key table one entry a cycle for a request with a key, then applies the update.
// ----------------------------------------------------------------------------
`default_nettype none
module pkl_engine import pkl_pkg::*; #(
   parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int unsigned KEY_BITS      = KEY_BITS_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  head_type      head,
   input  cfg_type       cfg,
   output logic          pop,
   output result_type    result
);
   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   eng_state_type state_ff, state_in;

   logic [KEY_BITS-1:0] key_mem [TABLE_ENTRIES];
   logic [15:0]         cnt_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;

   item_type            item_ff;
   logic [IDX_W-1:0]    addr_ff;
   logic                issue_ff;
   logic                cmp_vld_ff, cmp_last_ff;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic [KEY_BITS-1:0] key_rd_ff;
   logic [15:0]         cnt_rd_ff;
   logic                val_rd_ff;
   logic                hit_ff, free_ff;
   logic [IDX_W-1:0]    hit_idx_ff, free_idx_ff;
   logic [15:0]         hit_cnt_ff;
   result_type          result_ff, result_in;

   logic                wr_en, set_valid, clr_valid;
   logic [IDX_W-1:0]    wr_idx;
   logic [15:0]         wr_cnt, dec_cnt;
   logic                load, scan_done;

   assign load      = (state_ff == ST_IDLE) && head.vld;
   assign scan_done = cmp_vld_ff && cmp_last_ff;
   assign pop       = load;
   assign dec_cnt   = hit_cnt_ff - 16'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (head.vld) state_in = head.item.present ? ST_SCAN : ST_UPDATE;
         ST_SCAN:   if (scan_done) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // decision and table write
   always_comb begin
      result_in = '{vld: 1'b0, verdict: V_UNKNOWN, count_after: 16'd0, http_status: 10'd0};
      wr_en     = 1'b0;
      set_valid = 1'b0;
      clr_valid = 1'b0;
      wr_idx    = hit_idx_ff;
      wr_cnt    = 16'd0;
      case (state_ff)
         ST_UPDATE: begin
            result_in.vld = 1'b1;
            if (!item_ff.op) begin
               if (!item_ff.present) begin
                  result_in.verdict     = V_NOKEY;
                  result_in.http_status = cfg.reject_status;
               end else if (hit_ff) begin
                  if (hit_cnt_ff >= cfg.max_conns) begin
                     result_in.verdict     = V_OVER;
                     result_in.count_after = hit_cnt_ff;
                     result_in.http_status = cfg.reject_status;
                  end else begin
                     result_in.verdict     = V_ALLOWED;
                     result_in.count_after = hit_cnt_ff + 16'd1;
                     wr_en                 = 1'b1;
                     wr_cnt                = hit_cnt_ff + 16'd1;
                  end
               end else if (free_ff) begin
                  result_in.verdict     = V_NEW;
                  result_in.count_after = 16'd1;
                  wr_en                 = 1'b1;
                  set_valid             = 1'b1;
                  wr_idx                = free_idx_ff;
                  wr_cnt                = 16'd1;
               end else begin
                  result_in.verdict     = V_FULL;
                  result_in.http_status = cfg.reject_status;
               end
            end else if (hit_ff) begin
               result_in.count_after = dec_cnt;
               wr_en                 = 1'b1;
               wr_cnt                = dec_cnt;
               if (dec_cnt == 16'd0) begin
                  result_in.verdict = V_FREED;
                  clr_valid         = 1'b1;
               end else begin
                  result_in.verdict = V_RELEASED;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         issue_ff   <= 1'b0;
         cmp_vld_ff <= 1'b0;
         result_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         result_ff     <= result_in;
         if (set_valid) valid_ff[wr_idx] <= 1'b1;
         if (clr_valid) valid_ff[wr_idx] <= 1'b0;
         cmp_vld_ff    <= issue_ff;
         if (load) begin
            issue_ff <= head.item.present;
         end else if (issue_ff && addr_ff == LAST_IDX) begin
            issue_ff <= 1'b0;
         end
      end
   end

   // table memories: one read port for the scan, one write port for the update
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[wr_idx] <= wr_cnt;
         if (set_valid) key_mem[wr_idx] <= item_ff.key[KEY_BITS-1:0];
      end
      key_rd_ff <= key_mem[addr_ff];
      cnt_rd_ff <= cnt_mem[addr_ff];
      val_rd_ff <= valid_ff[addr_ff];
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff  <= addr_ff;
      cmp_last_ff <= (addr_ff == LAST_IDX);
      if (load) begin
         item_ff <= head.item;
         addr_ff <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         if (issue_ff) addr_ff <= addr_ff + IDX_W'(1);
         if (cmp_vld_ff) begin
            if (val_rd_ff && key_rd_ff == item_ff.key[KEY_BITS-1:0]) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= cmp_idx_ff;
               hit_cnt_ff <= cnt_rd_ff;
            end
            // keep the lowest free slot
            if (!val_rd_ff && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= cmp_idx_ff;
            end
         end
      end
   end

   assign result = result_ff;
endmodule
`default_nettype wire

### hw/rtl/per_key_concurrency_limiter.sv
// ----------------------------------------------------------------------------
// per_key_concurrency_limiter
// Table of client keys with a per-key count of active connections.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_op, req_key_present and req_client_key; the request
//   is taken at a clock edge where busy is low. Requests wait in a two-entry
//   queue ahead of the table engine.
//   Every request gives one result: rsp_valid is high for one cycle with
//   rsp_verdict, rsp_count_after and rsp_http_status. The receiver cannot
//   stall; results must be captured in that cycle.
//   A request with a key scans the whole table, one entry a cycle through the
//   key memory read port, then applies its update; a request without a key
//   goes straight to the update. The engine picks up the next queued request
//   only once the update of the previous one is done.
//   csr_wr_en writes max_conns (index 0) or reject_status (index 1); write
//   only while idle.
//   Reset empties the queue and marks every table entry free; registers
//   return to max_conns 1, reject_status 503. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module per_key_concurrency_limiter import pkl_pkg::*; #(
   parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int unsigned KEY_BITS      = KEY_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic                    req_op,
   input  wire logic                    req_key_present,
   input  wire logic [KEY_MAX_BITS-1:0] req_client_key,
   output logic                         rsp_valid,
   output logic [2:0]                   rsp_verdict,
   output logic [15:0]                  rsp_count_after,
   output logic [9:0]                   rsp_http_status,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wr_data
);
   cfg_type    cfg_ff;
   head_type   head;
   logic       pop;
   result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_conns     <= MAX_CONNS_RST;
         cfg_ff.reject_status <= REJECT_STATUS_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_CONNS:     cfg_ff.max_conns     <= csr_wr_data;
            CSR_REJECT_STATUS: cfg_ff.reject_status <= csr_wr_data[9:0];
            default: ;
         endcase
      end
   end

   pkl_front #(.KEY_BITS(KEY_BITS)) u_front (
      .clock, .reset, .start, .busy, .req_op, .req_key_present,
      .req_client_key, .pop, .head
   );

   pkl_engine #(.TABLE_ENTRIES(TABLE_ENTRIES), .KEY_BITS(KEY_BITS)) u_engine (
      .clock, .reset, .head, .cfg(cfg_ff), .pop, .result
   );

   assign rsp_valid       = result.vld;
   assign rsp_verdict     = result.verdict;
   assign rsp_count_after = result.count_after;
   assign rsp_http_status = result.http_status;
endmodule
`default_nettype wire

### hw/rtl/pkl_checker.sv
// ----------------------------------------------------------------------------
// pkl_checker
// Port-level checks on the limiter's result channel.
// ----------------------------------------------------------------------------
`default_nettype none
module pkl_checker import pkl_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [2:0]  rsp_verdict,
   input wire logic [15:0] rsp_count_after,
   input wire logic [9:0]  rsp_http_status
);
   a_reset_clean: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("busy or strobe after reset");
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("results back to back");
   a_new_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == V_NEW |-> rsp_count_after == 16'd1)
      else $error("new entry count not one");
   a_freed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == V_FREED || rsp_verdict == V_UNKNOWN)
      |-> rsp_count_after == 16'd0) else $error("freed count not zero");
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == V_NEW || rsp_verdict == V_ALLOWED ||
      rsp_verdict == V_RELEASED || rsp_verdict == V_FREED ||
      rsp_verdict == V_UNKNOWN) |-> rsp_http_status == 10'd0)
      else $error("status on allowed result");
endmodule

bind per_key_concurrency_limiter pkl_checker u_pkl_checker (
   .clock, .reset, .busy, .rsp_valid, .rsp_verdict, .rsp_count_after, .rsp_http_status
);
`default_nettype wire

### sim/tb_per_key_concurrency_limiter.sv
// ----------------------------------------------------------------------------
// tb_per_key_concurrency_limiter
// Self-checking bench for the per-key connection limit table. A directed table
// of requests runs first. Random acquire and release traffic follows over a
// small key pool, under several limit and status settings, including a pass
// that fills the whole table. Rows with a typed result are checked against it,
// every other result against an in-bench model of the table.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_per_key_concurrency_limiter;
   import pkl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ENTRIES   = TABLE_ENTRIES_DEF;
   localparam int unsigned WDOG_MAX  = 5000;
   localparam int unsigned DRAIN_CYC = ENTRIES + 40;
   localparam logic        OP_ACQUIRE = 1'b0;
   localparam logic        OP_RELEASE = 1'b1;
   localparam logic [63:0] KEY_ONES   = {64{1'b1}};

   typedef struct {
      logic        op;
      logic        present;
      logic [63:0] key;
      bit          typed;
      verdict_type verdict;
      logic [15:0] count;
      logic [9:0]  status;
   } dir_row_type;

   typedef struct {
      verdict_type verdict;
      logic [15:0] count;
      logic [9:0]  status;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_op = 1'b0;
   logic                  req_key_present = 1'b0;
   logic [KEY_MAX_BITS-1:0] req_client_key = '0;
   logic                  rsp_valid;
   logic [2:0]            rsp_verdict;
   logic [15:0]           rsp_count_after;
   logic [9:0]            rsp_http_status;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   // table model
   bit          tbl_valid [ENTRIES];
   logic [63:0] tbl_key   [ENTRIES];
   logic [15:0] tbl_count [ENTRIES];
   logic [15:0] lim_max_conns = MAX_CONNS_RST;
   logic [9:0]  lim_reject    = REJECT_STATUS_RST;

   outcome_type pending_results[$];
   logic [63:0] key_pool[$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          no_gaps = 1'b0;

   per_key_concurrency_limiter u_top (
      .clock, .reset, .start, .busy,
      .req_op, .req_key_present, .req_client_key,
      .rsp_valid, .rsp_verdict, .rsp_count_after, .rsp_http_status,
      .csr_wr_en, .csr_index, .csr_wr_data
   );

   always #6 clock = ~clock;

   function automatic outcome_type apply_request(logic op, logic present, logic [63:0] key);
      outcome_type o;
      int hit;
      int free_idx;
      hit = -1;
      free_idx = -1;
      o.count = '0;
      o.status = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (tbl_valid[i] && tbl_key[i] == key) hit = i;
         if (!tbl_valid[i]) free_idx = i;
      end
      if (!present) hit = -1;
      if (op == OP_ACQUIRE) begin
         if (!present) begin
            o.verdict = V_NOKEY;
            o.status = lim_reject;
         end else if (hit < 0 && free_idx < 0) begin
            o.verdict = V_FULL;
            o.status = lim_reject;
         end else if (hit < 0) begin
            tbl_valid[free_idx] = 1'b1;
            tbl_key[free_idx] = key;
            tbl_count[free_idx] = 16'd1;
            o.verdict = V_NEW;
            o.count = 16'd1;
         end else if (tbl_count[hit] >= lim_max_conns) begin
            o.verdict = V_OVER;
            o.count = tbl_count[hit];
            o.status = lim_reject;
         end else begin
            tbl_count[hit] = tbl_count[hit] + 16'd1;
            o.verdict = V_ALLOWED;
            o.count = tbl_count[hit];
         end
      end else if (hit < 0) begin
         o.verdict = V_UNKNOWN;
      end else begin
         tbl_count[hit] = tbl_count[hit] - 16'd1;
         o.count = tbl_count[hit];
         if (tbl_count[hit] == 16'd0) begin
            tbl_valid[hit] = 1'b0;
            o.verdict = V_FREED;
         end else begin
            o.verdict = V_RELEASED;
         end
      end
      return o;
   endfunction

   // drive one request, hold until taken, then log its expected outcome
   task automatic send_request(logic op, logic present, logic [63:0] key,
                               bit typed = 1'b0,
                               outcome_type fixed = '{V_NEW, 16'd0, 10'd0});
      int gap;
      outcome_type o;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_key_present <= present;
      req_client_key <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      o = apply_request(op, present, key);
      pending_results.push_back(typed ? fixed : o);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_MAX_CONNS) lim_max_conns = data;
      else lim_reject = data[9:0];
   endtask

   function automatic logic [63:0] random_key();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_traffic(int n, int acquire_pct);
      logic [63:0] k;
      logic        op;
      logic        present;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         op = ($urandom_range(0, 99) < acquire_pct) ? OP_ACQUIRE : OP_RELEASE;
         present = ($urandom_range(0, 9) != 0);
         if ($urandom_range(0, 9) == 0) k = random_key();
         else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
         send_request(op, present, k);
      end
      no_gaps = 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: verdict %0d count %0d status %0d",
                        rsp_verdict, rsp_count_after, rsp_http_status);
         end else begin
            e = pending_results.pop_front();
            if (rsp_verdict !== e.verdict || rsp_count_after !== e.count ||
                rsp_http_status !== e.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp verdict %0d count %0d status %0d, got %0d %0d %0d",
                           e.verdict, e.count, e.status,
                           rsp_verdict, rsp_count_after, rsp_http_status);
            end
         end
      end
   end

   // watchdog: cycles with neither a request taken nor a result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      dir_row_type rows[$];
      outcome_type fixed;
      for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
      rows = '{
         '{OP_ACQUIRE, 1'b0, 64'd0,    1'b1, V_NOKEY,   16'd0, 10'd503},
         '{OP_RELEASE, 1'b0, KEY_ONES, 1'b1, V_UNKNOWN, 16'd0, 10'd0},
         '{OP_RELEASE, 1'b1, 64'd5,    1'b1, V_UNKNOWN, 16'd0, 10'd0},
         '{OP_ACQUIRE, 1'b1, 64'd0,    1'b1, V_NEW,     16'd1, 10'd0},
         '{OP_ACQUIRE, 1'b1, 64'd0,    1'b1, V_OVER,    16'd1, 10'd503},
         '{OP_ACQUIRE, 1'b1, KEY_ONES, 1'b1, V_NEW,     16'd1, 10'd0},
         '{OP_ACQUIRE, 1'b0, 64'd0,    1'b1, V_NOKEY,   16'd0, 10'd503},
         '{OP_RELEASE, 1'b0, 64'd0,    1'b1, V_UNKNOWN, 16'd0, 10'd0},
         '{OP_RELEASE, 1'b1, 64'd0,    1'b1, V_FREED,   16'd0, 10'd0},
         '{OP_ACQUIRE, 1'b1, KEY_ONES, 1'b1, V_OVER,    16'd1, 10'd503},
         '{OP_ACQUIRE, 1'b1, 64'h8000_0000_0000_0000, 1'b1, V_NEW, 16'd1, 10'd0},
         '{OP_RELEASE, 1'b1, 64'd0,    1'b1, V_UNKNOWN, 16'd0, 10'd0},
         '{OP_RELEASE, 1'b1, KEY_ONES, 1'b1, V_FREED,   16'd0, 10'd0},
         '{OP_RELEASE, 1'b1, 64'h8000_0000_0000_0000, 1'b1, V_FREED, 16'd0, 10'd0},
         '{OP_ACQUIRE, 1'b1, 64'h5555_5555_5555_5555, 1'b0, V_NEW, 16'd0, 10'd0},
         '{OP_ACQUIRE, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, V_NEW, 16'd0, 10'd0},
         '{OP_RELEASE, 1'b1, 64'h5555_5555_5555_5555, 1'b0, V_NEW, 16'd0, 10'd0}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         fixed = '{rows[i].verdict, rows[i].count, rows[i].status};
         send_request(rows[i].op, rows[i].present, rows[i].key, rows[i].typed, fixed);
      end
      drain();

      // widest limit, reject status 599
      write_csr(CSR_MAX_CONNS, 16'hFFFF);
      write_csr(CSR_REJECT_STATUS, 16'd599);
      key_pool = '{64'd0, KEY_ONES, random_key(), random_key(), random_key(), random_key()};
      random_traffic(100, 65);
      drain();

      // zero limit: known keys denied, releases still count down
      write_csr(CSR_MAX_CONNS, 16'd0);
      write_csr(CSR_REJECT_STATUS, 16'd400);
      random_traffic(30, 50);
      drain();

      // fill the table past capacity, status outside the usual range
      write_csr(CSR_MAX_CONNS, 16'd3);
      write_csr(CSR_REJECT_STATUS, 16'h3FF);
      no_gaps = 1'b1;
      for (int i = 0; i < ENTRIES + 4; i++) begin
         key_pool.push_back(random_key());
         send_request(OP_ACQUIRE, 1'b1, key_pool[key_pool.size() - 1]);
      end
      no_gaps = 1'b0;
      random_traffic(60, 40);
      drain();

      repeat (DRAIN_CYC) @(posedge clock);
      if (pending_results.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire
